@@ sv/bls_pkg.sv @@
package bls_pkg;

    // Store geometry.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Command codes.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;
    localparam logic [1:0] CMD_DUMP = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;

    // Input word.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] push_value;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic               full_flag;
        logic               empty_flag;
        logic               last_of_run;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       ptr_zero;
        logic       out_busy;
    } t_dp_sts;

endpackage

@@ sv/bls_ctrl.sv @@
module bls_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bls_pkg::t_dp_sts   i_sts,
    output bls_pkg::t_ctrl_cmd o_cmd
);
    import bls_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic step;
    logic last;

    // A new word is taken only while no command is in progress.
    assign o_in_stall = (r_state != S_IDLE);

    // One result is produced per cycle in which the output register is free.
    assign step = (r_state == S_RUN) && !i_sts.out_busy;

    // A dump runs until the bottom entry; every other command gives one result.
    assign last = (i_sts.cmd != CMD_DUMP) || i_sts.empty || i_sts.ptr_zero;

    assign o_cmd.load = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.step = step;
    assign o_cmd.last = last;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (step && last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/bls_dpath.sv @@
module bls_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  bls_pkg::t_in_word  i_in_word,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output bls_pkg::t_out_word o_out_word,
    input  bls_pkg::t_ctrl_cmd i_cmd,
    output bls_pkg::t_dp_sts   o_sts
);
    import bls_pkg::*;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;

    logic [6:0]         r_cap;
    logic [1:0]         r_cmd;
    logic signed [31:0] r_value;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [ADDR_W-1:0]  r_ptr;
    logic [ADDR_W-1:0]  n_ptr;
    logic               r_out_valid;
    t_out_word          r_out_word;
    t_out_word          n_out_word;

    logic [CNT_W-1:0]   eff_cap;
    logic               is_full;
    logic               is_empty;
    logic               mem_we;

    // Capacity is clamped to the range 1 to DEPTH.
    always_comb begin
        if (r_cap == 7'd0) begin
            eff_cap = CNT_W'(1);
        end else if (CNT_W'(r_cap) > CNT_W'(DEPTH) || r_cap > 7'(DEPTH)) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
    end

    assign is_full  = (r_count >= eff_cap);
    assign is_empty = (r_count == '0);

    // Status for the controller.
    assign o_sts.cmd      = r_cmd;
    assign o_sts.empty    = is_empty;
    assign o_sts.ptr_zero = (r_ptr == '0);
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    // Result of the current step, count update and read pointer.
    always_comb begin
        n_count                = r_count;
        n_ptr                  = r_ptr;
        mem_we                 = 1'b0;
        n_out_word.status      = ST_OK;
        n_out_word.read_value  = '0;
        n_out_word.last_of_run = i_cmd.last;
        if (i_cmd.load) begin
            n_ptr = ADDR_W'(r_count - CNT_W'(1));
        end
        if (i_cmd.step) begin
            case (r_cmd)
                CMD_PUSH: begin
                    if (is_full) begin
                        n_out_word.status = ST_OVER;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                CMD_POP: begin
                    if (is_empty) begin
                        n_out_word.status = ST_UNDER;
                    end else begin
                        n_out_word.read_value = r_rd_data;
                        n_count               = r_count - CNT_W'(1);
                    end
                end
                CMD_PEEK: begin
                    if (is_empty) begin
                        n_out_word.status = ST_UNDER;
                    end else begin
                        n_out_word.read_value = r_rd_data;
                    end
                end
                default: begin
                    if (is_empty) begin
                        n_out_word.status = ST_UNDER;
                    end else begin
                        n_out_word.read_value = r_rd_data;
                        if (!i_cmd.last) begin
                            n_ptr = r_ptr - ADDR_W'(1);
                        end
                    end
                end
            endcase
        end
        n_out_word.full_flag  = (n_count >= eff_cap);
        n_out_word.empty_flag = (n_count == '0);
    end

    // Entry store: one write port, registered read that tracks the pointer.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= r_value;
        end
        r_rd_data <= r_mem[n_ptr];
    end

    // Item and pointer registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_in_word.cmd;
            r_value <= i_in_word.push_value;
        end
        r_ptr <= n_ptr;
    end

    // Control state: capacity, count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= 7'(DEPTH);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ sv/bounded_lifo_stack.sv @@
// Channel   Direction  Signals                               Word
// input     in         i_in_valid, o_in_stall, i_in_word     cmd, push_value
// output    out        o_out_valid, i_out_stall, o_out_word  status, read_value, flags, last
// config    in         i_cfg_we, i_cfg_wdata                 capacity
//
// Push, pop and peek first accept the word and start the store read, then form
// the result. A dump forms one result per entry, from the top entry down (a single
// underflow result when the stack is empty), paced by the single store read port.
// Reset is synchronous and active low; it clears the count and sets capacity to 64.
// A stalled output holds its word and pauses the command until it is taken.
module bounded_lifo_stack (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [6:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bls_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bls_pkg::t_out_word o_out_word
);
    import bls_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_dp_sts   dp_sts;

    // Sequencing of each command.
    bls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    // Entry store, count, capacity and output register.
    bls_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cmd       (ctrl_cmd),
        .o_sts       (dp_sts)
    );

endmodule

@@ verif/tb_bounded_lifo_stack.sv @@
`timescale 1ns / 100ps

import bls_pkg::*;

// Tracks the expected contents of the stack and the result words that each
// accepted command word should produce.
class stack_tracker;
    logic signed [31:0] entries [DEPTH];
    int unsigned        depth_used;
    logic [6:0]         capacity;
    t_out_word          pending [$];
    int                 fail_count;

    function new();
        depth_used = 0;
        capacity   = 7'd64;
        fail_count = 0;
    endfunction

    // A capacity of zero behaves as one, and anything above the store depth
    // behaves as the full depth.
    function int unsigned usable();
        if (capacity == 7'd0) return 1;
        if (capacity > DEPTH) return DEPTH;
        return capacity;
    endfunction

    function void set_capacity(input logic [6:0] value);
        capacity = value;
    endfunction

    // Flags are taken from the state after the command has taken effect.
    function void queue_result(input logic [1:0] status, input logic signed [31:0] value,
                               input logic last);
        t_out_word r;
        r.status      = status;
        r.read_value  = value;
        r.full_flag   = (depth_used >= usable());
        r.empty_flag  = (depth_used == 0);
        r.last_of_run = last;
        pending.push_back(r);
    endfunction

    function void note_command(input t_in_word w);
        logic signed [31:0] top;
        case (w.cmd)
            CMD_PUSH: begin
                if (depth_used >= usable()) begin
                    queue_result(ST_OVER, '0, 1'b1);
                end else begin
                    entries[depth_used] = w.push_value;
                    depth_used++;
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            CMD_POP: begin
                if (depth_used == 0) begin
                    queue_result(ST_UNDER, '0, 1'b1);
                end else begin
                    top = entries[depth_used - 1];
                    depth_used--;
                    queue_result(ST_OK, top, 1'b1);
                end
            end
            CMD_PEEK: begin
                if (depth_used == 0) begin
                    queue_result(ST_UNDER, '0, 1'b1);
                end else begin
                    queue_result(ST_OK, entries[depth_used - 1], 1'b1);
                end
            end
            default: begin
                // A dump walks from the top entry down to the bottom one.
                if (depth_used == 0) begin
                    queue_result(ST_UNDER, '0, 1'b1);
                end else begin
                    for (int i = depth_used; i > 0; i--) begin
                        queue_result(ST_OK, entries[i - 1], i == 1);
                    end
                end
            end
        endcase
    endfunction

    function void check_result(input t_out_word got);
        t_out_word want;
        if (pending.size() == 0) begin
            $error("result word with nothing expected: %p", got);
            fail_count++;
            return;
        end
        want = pending.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
            fail_count++;
        end
        if (got.full_flag !== want.full_flag) begin
            $error("full_flag: expected %0b, actual %0b", want.full_flag, got.full_flag);
            fail_count++;
        end
        if (got.empty_flag !== want.empty_flag) begin
            $error("empty_flag: expected %0b, actual %0b", want.empty_flag, got.empty_flag);
            fail_count++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                   got.last_of_run);
            fail_count++;
        end
    endfunction
endclass

module tb_bounded_lifo_stack;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 55;
    localparam int PHASES       = 8;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [6:0] i_cfg_wdata = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_word  o_out_word;

    stack_tracker tracker;
    bit           calm         = 1'b0;
    bit           hold_request = 1'b0;
    int           hold_left    = 0;

    bounded_lifo_stack dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 28);
        end
    end

    // Every result word taken at a rising edge is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_out_word);
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    // Offers one command word, with a random gap first, and waits until it is taken.
    // Entered and left just after a falling edge.
    task automatic send_word(input logic [1:0] cmd, input logic [31:0] value);
        while (!calm && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_in_word.cmd        <= cmd;
        i_in_word.push_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_command(i_in_word);
        @(negedge i_clk);
    endtask

    // Writes the capacity once the block has drained every expected word.
    task automatic set_capacity(input logic [6:0] value);
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_capacity(value);
    endtask

    initial begin : main
        logic [6:0]  phase_cap  [PHASES];
        int          push_share [PHASES];
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] value;

        phase_cap  = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd16, 7'd0};
        push_share = '{75, 55, 55, 70, 50, 80, 45, 60};
        phase_cap[PHASES - 1] = 7'($urandom_range(127));

        tracker = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty stack, value extremes, overflow at a small capacity.
        set_capacity(7'd2);
        send_word(CMD_POP,  $urandom);
        send_word(CMD_PEEK, $urandom);
        send_word(CMD_DUMP, $urandom);
        send_word(CMD_PUSH, 32'h8000_0000);
        send_word(CMD_PUSH, 32'h7FFF_FFFF);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_PEEK, $urandom);
        send_word(CMD_DUMP, $urandom);

        // Capacity lowered below the count: pushes overflow, stored entries stay reachable.
        set_capacity(7'd1);
        send_word(CMD_PUSH, 32'h0000_0000);
        send_word(CMD_PEEK, $urandom);
        send_word(CMD_DUMP, $urandom);
        send_word(CMD_POP,  $urandom);
        send_word(CMD_POP,  $urandom);
        send_word(CMD_POP,  $urandom);

        // A capacity of zero acts as one.
        set_capacity(7'd0);
        send_word(CMD_PUSH, 32'h5555_5555);
        send_word(CMD_PUSH, 32'hAAAA_AAAA);
        send_word(CMD_POP,  $urandom);

        // A capacity above the depth acts as the full depth.
        set_capacity(7'd127);
        send_word(CMD_PUSH, 32'h0000_0000);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_DUMP, $urandom);

        // Random phases, each at its own capacity and push share.
        for (int p = 0; p < PHASES; p++) begin
            set_capacity(phase_cap[p]);
            calm = (p == 5);
            if (p == 3) hold_request = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < push_share[p]) begin
                    cmd = CMD_PUSH;
                end else begin
                    pick = $urandom_range(99);
                    cmd  = (pick < 55) ? CMD_POP : (pick < 82) ? CMD_PEEK : CMD_DUMP;
                end
                case ($urandom_range(7))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'h0000_0000;
                    3:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                send_word(cmd, value);
            end
        end
        calm = 1'b0;

        // Drain what is still expected, then leave time for any stray words to show.
        i_in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bls_pkg.sv
sv/bls_ctrl.sv
sv/bls_dpath.sv
sv/bounded_lifo_stack.sv
verif/tb_bounded_lifo_stack.sv
